// ===== rtl/assert_macros.svh =====
// Assertion macros used by the friction cone projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FCP_ASSERT(lbl, clk, rst, prop, msg)
`define FCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/fcp_pkg.sv =====
// Shared types, constants and the square root step for the friction cone projection.
package fcp_pkg;

  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [30:0]        normal;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
    logic signed [31:0] target;
    logic [62:0]        sqa;
    logic [62:0]        sqb;
    logic [61:0]        mun_full;
  } fcp_work_t;

  typedef struct packed {
    logic signed [32:0] k;
    logic [31:0]        rad0;
    logic [63:0]        p_wide;
  } fcp_derived_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] root;
  } fcp_sqrt_t;

  function automatic fcp_sqrt_t sqrt_step(fcp_sqrt_t cur, logic [1:0] pair);
    logic [34:0] rem_t;
    logic [34:0] trial;
    logic [34:0] diff;
    fcp_sqrt_t   nxt;
    rem_t = {cur.rem, pair};
    trial = {1'b0, cur.root, 2'b01};
    diff  = rem_t - trial;
    if (rem_t >= trial) begin
      nxt.rem  = diff[32:0];
      nxt.root = {cur.root[30:0], 1'b1};
    end else begin
      nxt.rem  = rem_t[32:0];
      nxt.root = {cur.root[30:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/fcp_derive.sv =====
// Sequencer that derives the cone constants from the configuration registers.
module fcp_derive #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [30:0]          perturbation,
  input  logic signed [31:0]   cone_shift,
  output logic                 busy,
  output fcp_pkg::fcp_derived_t derived
);
  import fcp_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_ROOTP, ST_KSUM, ST_KSQ, ST_SUB, ST_RAD, ST_DONE, ST_IDLE
  } state_t;

  localparam logic [4:0] LAST = 5'(SQRT_STEPS - 1);

  state_t             state;
  logic [63:0]        v;
  fcp_sqrt_t          acc;
  logic [4:0]         cnt;
  logic [63:0]        p_wide;
  logic signed [32:0] k;
  logic [63:0]        ksq;
  logic [31:0]        rad0;
  logic [63:0]        pw;
  logic [32:0]        kneg;
  logic [31:0]        kmag;

  assign pw   = 64'(perturbation) << FRAC_BITS;
  assign kneg = -k;
  assign kmag = k[32] ? kneg[31:0] : k[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else if (start) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: begin
          v      <= pw;
          p_wide <= pw;
          acc    <= '0;
          cnt    <= '0;
          state  <= ST_ROOTP;
        end
        ST_ROOTP: begin
          acc <= sqrt_step(acc, v[63:62]);
          v   <= {v[61:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == LAST) state <= ST_KSUM;
        end
        ST_KSUM: begin
          k     <= $signed({1'b0, acc.root}) + $signed({cone_shift[31], cone_shift});
          state <= ST_KSQ;
        end
        ST_KSQ: begin
          ksq   <= {32'b0, kmag} * {32'b0, kmag};
          state <= ST_SUB;
        end
        ST_SUB: begin
          v     <= (ksq >= p_wide) ? ksq - p_wide : '0;
          acc   <= '0;
          cnt   <= '0;
          state <= ST_RAD;
        end
        ST_RAD: begin
          acc <= sqrt_step(acc, v[63:62]);
          v   <= {v[61:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == LAST) state <= ST_DONE;
        end
        ST_DONE: begin
          rad0  <= acc.root;
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state != ST_IDLE);
  assign derived.k      = k;
  assign derived.rad0   = rad0;
  assign derived.p_wide = p_wide;

endmodule

// ===== rtl/fcp_front.sv =====
// Front end: takes input words, clamps the normal and forms the squares and mu*n.
module fcp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               block,
  input  logic [30:0]        friction_coeff,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] normal_in,
  input  logic signed [31:0] tangent_a_in,
  input  logic signed [31:0] tangent_b_in,
  input  logic signed [31:0] target_level,
  output logic               push_valid,
  input  logic               push_ready,
  output fcp_pkg::fcp_work_t push_word
);
  import fcp_pkg::*;

  logic               v0;
  logic               v1;
  logic [30:0]        s0_normal;
  logic signed [31:0] s0_ta;
  logic signed [31:0] s0_tb;
  logic signed [31:0] s0_target;
  fcp_work_t          s1;
  logic               en0;
  logic               en1;
  logic               accept;
  logic [31:0]        neg_a;
  logic [31:0]        neg_b;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic [63:0]        sqa_full;
  logic [63:0]        sqb_full;
  logic [61:0]        mun_full;

  assign en1      = !v1 || push_ready;
  assign en0      = !v0 || en1;
  assign in_ready = en0 && !block;
  assign accept   = in_valid && in_ready;

  assign neg_a    = -s0_ta;
  assign neg_b    = -s0_tb;
  assign mag_a    = s0_ta[31] ? neg_a : s0_ta;
  assign mag_b    = s0_tb[31] ? neg_b : s0_tb;
  assign sqa_full = {32'b0, mag_a} * {32'b0, mag_a};
  assign sqb_full = {32'b0, mag_b} * {32'b0, mag_b};
  assign mun_full = {31'b0, friction_coeff} * {31'b0, s0_normal};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (en0) v0 <= accept;
      if (en1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && accept) begin
      s0_normal <= normal_in[31] ? 31'd0 : normal_in[30:0];
      s0_ta     <= tangent_a_in;
      s0_tb     <= tangent_b_in;
      s0_target <= target_level;
    end
    if (en1) begin
      s1.normal   <= s0_normal;
      s1.ta       <= s0_ta;
      s1.tb       <= s0_tb;
      s1.target   <= s0_target;
      s1.sqa      <= sqa_full[62:0];
      s1.sqb      <= sqb_full[62:0];
      s1.mun_full <= mun_full;
    end
  end

  assign push_valid = v1;
  assign push_word  = s1;

endmodule

// ===== rtl/fcp_queue.sv =====
// Four-word queue between the front end and the back end.
module fcp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  fcp_pkg::fcp_work_t push_word,
  output logic               pop_valid,
  input  logic               pop,
  output fcp_pkg::fcp_work_t pop_word
);
  import fcp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  fcp_work_t     mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_word;
  end

endmodule

// ===== rtl/fcp_back.sv =====
// Back end: square root pipes, cone value, projection test and rescale divider.
module fcp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  fcp_pkg::fcp_work_t    q_word,
  output logic                  q_pop,
  input  fcp_pkg::fcp_derived_t derived,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [30:0]           normal_out,
  output logic signed [31:0]    tangent_a_out,
  output logic signed [31:0]    tangent_b_out,
  output logic signed [31:0]    cone_value,
  output logic                  was_projected
);
  import fcp_pkg::*;

  localparam int DIV_STEPS = 33;

  typedef struct packed {
    logic [30:0]        normal;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
    logic signed [31:0] target;
    logic [53:0]        mun;
  } side_t;

  typedef struct packed {
    logic [30:0]        normal;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
    logic signed [31:0] cone;
    logic               proj;
    logic               neg_a;
    logic               neg_b;
    logic [31:0]        norm;
  } tail_t;

  function automatic logic [31:0] finish(logic [DIV_STEPS-1:0] q, logic neg,
                                         logic [31:0] t, logic proj, logic [31:0] norm);
    logic [31:0] cap;
    cap = (q > DIV_STEPS'(33'h080000000)) ? 32'h80000000 : q[31:0];
    if (!proj)            return t;
    else if (norm == '0)  return '0;
    else if (neg)         return -cap;
    else if (cap[31])     return 32'h7FFFFFFF;
    else                  return cap;
  endfunction

  logic en;
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  // square root pipes: x = tsq + p, and tsq for the tangential norm
  logic        sq_valid [0:SQRT_STEPS];
  fcp_sqrt_t   sx       [0:SQRT_STEPS];
  fcp_sqrt_t   st       [0:SQRT_STEPS];
  side_t       sside    [0:SQRT_STEPS];
  logic [63:0] vx       [0:SQRT_STEPS-1];
  logic [63:0] vt       [0:SQRT_STEPS-1];
  logic [63:0] tsq0;
  logic [61:0] mun_sh;

  assign tsq0   = {1'b0, q_word.sqa} + {1'b0, q_word.sqb};
  assign mun_sh = q_word.mun_full >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) sq_valid[0] <= 1'b0;
    else if (en) sq_valid[0] <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0]           <= tsq0 + derived.p_wide;
      vt[0]           <= tsq0;
      sx[0]           <= '0;
      st[0]           <= '0;
      sside[0].normal <= q_word.normal;
      sside[0].ta     <= q_word.ta;
      sside[0].tb     <= q_word.tb;
      sside[0].target <= q_word.target;
      sside[0].mun    <= mun_sh[53:0];
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) sq_valid[j+1] <= 1'b0;
      else if (en) sq_valid[j+1] <= sq_valid[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sx[j+1]    <= sqrt_step(sx[j], vx[j][63:62]);
        st[j+1]    <= sqrt_step(st[j], vt[j][63:62]);
        sside[j+1] <= sside[j];
      end
    end
    if (j < SQRT_STEPS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          vx[j+1] <= {vx[j][61:0], 2'b00};
          vt[j+1] <= {vt[j][61:0], 2'b00};
        end
      end
    end
  end

  // cone value
  logic               c_valid;
  logic signed [63:0] c_r;
  side_t              c_side;
  logic [31:0]        c_norm;
  logic signed [63:0] c_calc;

  assign c_calc = $signed({32'b0, sx[SQRT_STEPS].root})
                - $signed({10'b0, sside[SQRT_STEPS].mun})
                - $signed({{31{derived.k[32]}}, derived.k});

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= sq_valid[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_calc;
      c_side <= sside[SQRT_STEPS];
      c_norm <= st[SQRT_STEPS].root;
    end
  end

  // projection test and target radius
  logic               p_valid;
  tail_t              p_tail;
  logic [32:0]        p_radius;
  logic [31:0]        p_mag_a;
  logic [31:0]        p_mag_b;
  logic signed [34:0] rad_sum;
  logic [31:0]        neg_a;
  logic [31:0]        neg_b;
  logic [31:0]        cone_sat;

  assign rad_sum = $signed({3'b0, derived.rad0})
                 + $signed({{3{c_side.target[31]}}, c_side.target});
  assign neg_a   = -c_side.ta;
  assign neg_b   = -c_side.tb;

  always_comb begin
    if (c_r > 64'sd2147483647)        cone_sat = 32'h7FFFFFFF;
    else if (c_r < -64'sd2147483648)  cone_sat = 32'h80000000;
    else                              cone_sat = c_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_tail.normal <= c_side.normal;
      p_tail.ta     <= c_side.ta;
      p_tail.tb     <= c_side.tb;
      p_tail.cone   <= cone_sat;
      p_tail.proj   <= c_r > $signed({{32{c_side.target[31]}}, c_side.target});
      p_tail.neg_a  <= c_side.ta[31];
      p_tail.neg_b  <= c_side.tb[31];
      p_tail.norm   <= c_norm;
      p_radius      <= rad_sum[34] ? 33'd0 : rad_sum[32:0];
      p_mag_a       <= c_side.ta[31] ? neg_a : c_side.ta;
      p_mag_b       <= c_side.tb[31] ? neg_b : c_side.tb;
    end
  end

  // rescale products, then one quotient bit per stage
  logic                 dv_valid [0:DIV_STEPS];
  tail_t                dv_tail  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_qa    [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_qb    [0:DIV_STEPS];
  logic [63:0]          dv_ra    [0:DIV_STEPS-1];
  logic [63:0]          dv_rb    [0:DIV_STEPS-1];
  logic [64:0]          prod_a;
  logic [64:0]          prod_b;

  assign prod_a = {33'b0, p_mag_a} * {32'b0, p_radius};
  assign prod_b = {33'b0, p_mag_b} * {32'b0, p_radius};

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else if (en) dv_valid[0] <= p_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_tail[0] <= p_tail;
      dv_ra[0]   <= prod_a[63:0];
      dv_rb[0]   <= prod_b[63:0];
      dv_qa[0]   <= '0;
      dv_qb[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [63:0] d;
    logic        ge_a;
    logic        ge_b;
    assign d    = {32'b0, dv_tail[j].norm} << (DIV_STEPS - 1 - j);
    assign ge_a = dv_ra[j] >= d;
    assign ge_b = dv_rb[j] >= d;
    always_ff @(posedge clk) begin
      if (rst) dv_valid[j+1] <= 1'b0;
      else if (en) dv_valid[j+1] <= dv_valid[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_tail[j+1] <= dv_tail[j];
        dv_qa[j+1]   <= {dv_qa[j][DIV_STEPS-2:0], ge_a};
        dv_qb[j+1]   <= {dv_qb[j][DIV_STEPS-2:0], ge_b};
      end
    end
    if (j < DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dv_ra[j+1] <= ge_a ? dv_ra[j] - d : dv_ra[j];
          dv_rb[j+1] <= ge_b ? dv_rb[j] - d : dv_rb[j];
        end
      end
    end
  end

  // output register
  tail_t ft;
  assign ft = dv_tail[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_valid[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_out    <= ft.normal;
      tangent_a_out <= finish(dv_qa[DIV_STEPS], ft.neg_a, ft.ta, ft.proj, ft.norm);
      tangent_b_out <= finish(dv_qb[DIV_STEPS], ft.neg_b, ft.tb, ft.proj, ft.norm);
      cone_value    <= ft.cone;
      was_projected <= ft.proj;
    end
  end

endmodule

// ===== rtl/friction_cone_project.sv =====
// Smoothed friction cone projection, fully pipelined.
// An accepted word passes the front end registers, the queue, the 32-stage root pipes, the
// cone, test and product registers and the 33-stage divider. Throughput: one word per cycle
// while no rederivation or out_ready stall holds it; a four-word queue decouples front and
// back end stalls. After reset and after each register write the cone constants are rederived,
// during which in_ready is low. Reset is synchronous, active high, and clears all control state.
`include "assert_macros.svh"
module friction_cone_project #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] normal_in,
  input  logic signed [31:0] tangent_a_in,
  input  logic signed [31:0] tangent_b_in,
  input  logic signed [31:0] target_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        normal_out,
  output logic signed [31:0] tangent_a_out,
  output logic signed [31:0] tangent_b_out,
  output logic signed [31:0] cone_value,
  output logic               was_projected
);
  import fcp_pkg::*;

  localparam logic [1:0] REG_MU    = 2'd0;
  localparam logic [1:0] REG_PERT  = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  logic [30:0]        friction_coeff;
  logic [30:0]        perturbation;
  logic signed [31:0] cone_shift;
  logic               cfg_we;
  logic               derive_busy;
  fcp_derived_t       derived;
  logic               push_valid;
  logic               push_ready;
  fcp_work_t          push_word;
  logic               q_valid;
  logic               q_pop;
  fcp_work_t          q_word;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      friction_coeff <= 31'd32768;
      perturbation   <= '0;
      cone_shift     <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_MU:    friction_coeff <= pwdata[30:0];
        REG_PERT:  perturbation   <= pwdata[30:0];
        REG_SHIFT: cone_shift     <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MU:    prdata = {1'b0, friction_coeff};
      REG_PERT:  prdata = {1'b0, perturbation};
      REG_SHIFT: prdata = cone_shift;
      default:   prdata = '0;
    endcase
  end

  fcp_derive #(.FRAC_BITS(FRAC_BITS)) u_derive (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_we),
    .perturbation (perturbation),
    .cone_shift   (cone_shift),
    .busy         (derive_busy),
    .derived      (derived)
  );

  fcp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .block          (derive_busy),
    .friction_coeff (friction_coeff),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .normal_in      (normal_in),
    .tangent_a_in   (tangent_a_in),
    .tangent_b_in   (tangent_b_in),
    .target_level   (target_level),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_word      (push_word)
  );

  fcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_word   (q_word)
  );

  fcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .q_pop         (q_pop),
    .derived       (derived),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .normal_out    (normal_out),
    .tangent_a_out (tangent_a_out),
    .tangent_b_out (tangent_b_out),
    .cone_value    (cone_value),
    .was_projected (was_projected)
  );

  `FCP_ASSERT(a_busy_blocks_input, clk, rst, derive_busy |-> !in_ready, "input taken while constants rederive")
  `FCP_ASSERT_NEXT(a_write_restarts, clk, rst, cfg_we, derive_busy, "register write did not restart derivation")
  `FCP_ASSERT_NEXT(a_stall_keeps_word, clk, rst, out_valid && !out_ready, out_valid && $stable(cone_value), "stalled result word changed")

endmodule

// ===== tb/friction_cone_checker.sv =====
// Checker for the friction cone projection: predicts each result word and compares it.
module friction_cone_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] normal_in,
  input  logic signed [31:0] tangent_a_in,
  input  logic signed [31:0] tangent_b_in,
  input  logic signed [31:0] target_level,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [30:0]        normal_out,
  input  logic signed [31:0] tangent_a_out,
  input  logic signed [31:0] tangent_b_out,
  input  logic signed [31:0] cone_value,
  input  logic               was_projected,
  output int                 failures,
  output int                 pending
);

  localparam int FRAC = 16;
  localparam logic [3:0] ADDR_MU    = 4'd0;
  localparam logic [3:0] ADDR_PERT  = 4'd4;
  localparam logic [3:0] ADDR_SHIFT = 4'd8;

  typedef struct {
    logic [30:0]        normal;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
    logic signed [31:0] cone;
    logic               proj;
  } cone_word_t;

  logic [30:0]        mu;
  logic [30:0]        pert;
  logic signed [31:0] shift;
  cone_word_t         cone_words_due[$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint scale_tangent(longint t, longint unsigned r, longint unsigned nrm);
    longint unsigned q;
    if (nrm == 0) return 0;
    q = (abs64(t) * r) / nrm;
    if (q > 64'h80000000) q = 64'h80000000;
    return clamp32((t < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic cone_word_t project_force(logic signed [31:0] n_in, logic signed [31:0] a_in,
                                               logic signed [31:0] b_in, logic signed [31:0] tgt);
    cone_word_t      w;
    longint          n, a, b, c, k, radius;
    longint unsigned pw, tsq, root_r2, root_p, mun, ksq, rad0, nrm;
    n  = n_in;
    a  = a_in;
    b  = b_in;
    pw = longint'(pert) << FRAC;
    if (n < 0) n = 0;
    tsq     = abs64(a) * abs64(a) + abs64(b) * abs64(b);
    root_r2 = floor_sqrt(tsq + pw);
    root_p  = floor_sqrt(pw);
    mun     = (longint'(mu) * longint'(n)) >> FRAC;
    c = longint'(root_r2) - longint'(mun) - longint'(root_p) - longint'(shift);
    w.proj = 1'b0;
    if (c > longint'(tgt)) begin
      w.proj = 1'b1;
      k      = longint'(root_p) + longint'(shift);
      ksq    = abs64(k) * abs64(k);
      rad0   = (ksq >= pw) ? floor_sqrt(ksq - pw) : 0;
      radius = longint'(rad0) + longint'(tgt);
      if (radius < 0) radius = 0;
      nrm = floor_sqrt(tsq);
      a   = scale_tangent(a, radius, nrm);
      b   = scale_tangent(b, radius, nrm);
    end
    w.normal = n[30:0];
    w.ta     = a[31:0];
    w.tb     = b[31:0];
    w.cone   = clamp32(c);
    return w;
  endfunction

  assign pending = cone_words_due.size();

  always @(posedge clk) begin
    cone_word_t want;
    int         errs;
    errs = 0;
    if (rst) begin
      mu    <= 31'd32768;
      pert  <= '0;
      shift <= '0;
      failures <= 0;
      cone_words_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_MU:    mu    <= pwdata[30:0];
          ADDR_PERT:  pert  <= pwdata[30:0];
          ADDR_SHIFT: shift <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        cone_words_due.push_back(project_force(normal_in, tangent_a_in, tangent_b_in,
                                               target_level));
      if (out_valid && out_ready) begin
        if (cone_words_due.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          want = cone_words_due.pop_front();
          if (normal_out !== want.normal) begin
            $error("normal_out: expected %0d got %0d", want.normal, normal_out);
            errs++;
          end
          if (tangent_a_out !== want.ta) begin
            $error("tangent_a_out: expected %0d got %0d", want.ta, tangent_a_out);
            errs++;
          end
          if (tangent_b_out !== want.tb) begin
            $error("tangent_b_out: expected %0d got %0d", want.tb, tangent_b_out);
            errs++;
          end
          if (cone_value !== want.cone) begin
            $error("cone_value: expected %0d got %0d", want.cone, cone_value);
            errs++;
          end
          if (was_projected !== want.proj) begin
            $error("was_projected: expected %0d got %0d", want.proj, was_projected);
            errs++;
          end
        end
      end
      if (errs != 0) failures <= failures + errs;
    end
  end

endmodule

// ===== tb/tb_friction_cone_project.sv =====
// Testbench top for the friction cone projection: stimulus, register setup and verdict.
module tb_friction_cone_project;

  localparam int REG_MU    = 0;
  localparam int REG_PERT  = 1;
  localparam int REG_SHIFT = 2;
  localparam int LIMIT     = 400000;
  localparam int DRAIN     = 120;
  localparam logic [31:0] MAX_POS = 32'h7FFFFFFF;
  localparam logic [31:0] MAX_NEG = 32'h80000000;
  localparam logic [31:0] ONE     = 32'h00010000;

  logic               clk, rst;
  logic               psel, penable, pwrite, pready;
  logic [3:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] normal_in, tangent_a_in, tangent_b_in, target_level;
  logic [30:0]        normal_out;
  logic signed [31:0] tangent_a_out, tangent_b_out, cone_value;
  logic               was_projected;
  int                 failures, pending;
  int                 send_idle, recv_stall;
  bit                 hold_req;
  int                 cycles;

  friction_cone_project DUT (.*);
  friction_cone_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("** friction_cone_project: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !rst) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic write_reg(int idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx * 4); pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] m, logic [31:0] p, logic [31:0] s);
    settle();
    write_reg(REG_MU, m);
    write_reg(REG_PERT, p);
    write_reg(REG_SHIFT, s);
  endtask

  task automatic send_word(logic [31:0] n, logic [31:0] a, logic [31:0] b, logic [31:0] t);
    normal_in <= n; tangent_a_in <= a; tangent_b_in <= b; target_level <= t;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_field();
    int k;
    k = $urandom_range(9);
    if (k < 4) return $urandom;
    if (k < 8) return $urandom_range(0, 32'h80000) - 32'h40000;
    case ($urandom_range(4))
      0: return MAX_POS;
      1: return MAX_NEG;
      2: return 0;
      3: return 32'hFFFFFFFF;
      default: return 1;
    endcase
  endfunction

  task automatic random_phase(int count, int s_idle, int r_stall);
    send_idle  = s_idle;
    recv_stall = r_stall;
    repeat (count) send_word(pick_field(), pick_field(), pick_field(), pick_field());
    in_valid <= 0;
  endtask

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; normal_in = 0; tangent_a_in = 0; tangent_b_in = 0; target_level = 0;
    send_idle = 0; recv_stall = 0; hold_req = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // extremes and special cases at reset settings
    send_word(0, 0, 0, 0);
    send_word(MAX_NEG, 3 * ONE, 4 * ONE, 0);
    send_word(MAX_POS, MAX_POS, MAX_NEG, MAX_POS);
    send_word(0, MAX_NEG, MAX_NEG, 0);
    send_word(0, MAX_NEG, MAX_NEG, MAX_NEG);
    send_word(0, 0, 0, MAX_NEG);
    send_word(ONE, 3 * ONE, 4 * ONE, ONE);
    send_word(0, MAX_POS, 1, MAX_POS - 5);
    send_word(ONE, 32'hFFFFFFFF, 1, 32'hFFFF0000);
    in_valid <= 0;

    configure(MAX_POS, MAX_POS, MAX_NEG);
    send_word(0, 0, 0, MAX_NEG);
    send_word(MAX_POS, MAX_POS, MAX_POS, MAX_POS);
    send_word(ONE, ONE, 32'hFFFF0000, 0);
    send_word(0, MAX_NEG, 0, 32'h40000000);
    in_valid <= 0;

    // k = 0 so the radius argument goes negative
    configure(ONE, ONE, 32'hFFFF0000);
    send_word(0, 5 * ONE, 0, 0);
    send_word(0, 0, 0, MAX_NEG);
    send_word(ONE, ONE, ONE, 32'hFFFF0000);
    in_valid <= 0;

    configure(0, 0, MAX_POS);
    send_word(MAX_POS, MAX_POS, MAX_POS, MAX_NEG);
    send_word(0, MAX_NEG, MAX_POS, MAX_POS);
    in_valid <= 0;

    configure(32'h8000, 0, 0);
    random_phase(90, 0, 0);
    configure($urandom & MAX_POS, $urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000));
    random_phase(90, 54, 0);
    configure($urandom, $urandom, $urandom);
    random_phase(90, 0, 54);
    configure(MAX_POS, 0, MAX_NEG);
    random_phase(90, 28, 28);

    configure(32'h8000, ONE, 0);
    send_idle = 0; recv_stall = 0;
    hold_req = 1;
    random_phase(90, 0, 0);

    settle();
    if (failures == 0)
      $display("** friction_cone_project: PASSED **");
    else
      $display("** friction_cone_project: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fcp_pkg.sv
rtl/fcp_derive.sv
rtl/fcp_front.sv
rtl/fcp_queue.sv
rtl/fcp_back.sv
rtl/friction_cone_project.sv
tb/friction_cone_checker.sv
tb/tb_friction_cone_project.sv
